// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the priority queue RTL.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks that a condition holds at every clock edge outside reset.
`define BPQ_ASSERT_ALWAYS(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a condition at one edge implies another at the next edge.
`define BPQ_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define BPQ_ASSERT_ALWAYS(name, clk, rst, expr, msg)
`define BPQ_ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

// ----- rtl/core/bpq_pkg.sv -----
// Shared types, constants and address helper for the bounded priority queue.
// Depends on nothing; every RTL module of the block uses it.
`timescale 1ns / 1ps

package bpq_pkg;

   localparam int CAPACITY = 16;
   localparam int PTR_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 8;
   localparam int OCC_W    = 5;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic      en;
      ptr_type   addr;
      entry_type data;
   } ram_wr_type;

   typedef struct packed {
      logic    en;
      ptr_type addr;
   } ram_rd_type;

   typedef struct packed {
      logic             out_valid;
      entry_type        item;
      logic             dropped;
      logic [OCC_W-1:0] occupancy;
   } result_type;

   // Physical slot of a logical queue position: the list is a ring that
   // starts at the head slot.
   function automatic ptr_type phys_addr(ptr_type head, ptr_type offs);
      logic [PTR_W:0] sum;
      sum = {1'b0, head} + {1'b0, offs};
      if (sum >= (PTR_W + 1)'(CAPACITY)) begin
         sum = sum - (PTR_W + 1)'(CAPACITY);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

// ----- rtl/core/bpq_ram.sv -----
// Entry store of the priority queue: one write port, one registered read port.
// Depends on bpq_pkg for the entry and port types.
`timescale 1ns / 1ps

module bpq_ram (
   input  logic                   clock,
   input  bpq_pkg::ram_wr_type    wr,
   input  bpq_pkg::ram_rd_type    rd,
   output bpq_pkg::entry_type     rd_data
);

   bpq_pkg::entry_type mem [bpq_pkg::CAPACITY];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data <= mem[rd.addr];
      end
   end

endmodule

// ----- rtl/core/bpq_ctrl.sv -----
// Sequencer of the priority queue: head pointer, count, and the sorted-insert scan.
// Depends on bpq_pkg and assert_macros.svh; drives the entry store bpq_ram.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_command,
   input  bpq_pkg::entry_type     req_item,
   output logic                   res_valid,
   output bpq_pkg::result_type    res,
   input  logic                   res_taken,
   output bpq_pkg::ram_wr_type    ram_wr,
   output bpq_pkg::ram_rd_type    ram_rd,
   input  bpq_pkg::entry_type     ram_rd_data
);

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
   localparam logic [ST_W-1:0] ST_POP   = 3'd1;
   localparam logic [ST_W-1:0] ST_EVICT = 3'd2;
   localparam logic [ST_W-1:0] ST_SCAN  = 3'd3;
   localparam logic [ST_W-1:0] ST_PLACE = 3'd4;
   localparam logic [ST_W-1:0] ST_DONE  = 3'd5;

   logic [ST_W-1:0]      state_ff, state_in;
   bpq_pkg::ptr_type     head_ff, head_in;
   bpq_pkg::cnt_type     count_ff, count_in;
   bpq_pkg::ptr_type     k_ff, k_in;
   bpq_pkg::entry_type   item_ff, item_in;
   logic                 full_ff, full_in;
   bpq_pkg::result_type  res_ff, res_in;
   logic                 insert_done;

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      k_in        = k_ff;
      item_in     = item_ff;
      full_in     = full_ff;
      res_in      = res_ff;
      ram_wr      = '0;
      ram_rd      = '0;
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      insert_done = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in = req_item;
               res_in  = '0;
               if (req_command == bpq_pkg::CMD_DEQUEUE) begin
                  if (count_ff == '0) begin
                     state_in = ST_DONE;
                  end else begin
                     ram_rd.en   = 1'b1;
                     ram_rd.addr = head_ff;
                     state_in    = ST_POP;
                  end
               end else if (count_ff == '0) begin
                  ram_wr.en   = 1'b1;
                  ram_wr.addr = head_ff;
                  ram_wr.data = req_item;
                  count_in    = bpq_pkg::cnt_type'(1);
                  state_in    = ST_DONE;
               end else begin
                  // Start at the tail and walk toward the head.
                  k_in        = bpq_pkg::PTR_W'(count_ff - bpq_pkg::cnt_type'(1));
                  ram_rd.en   = 1'b1;
                  ram_rd.addr = bpq_pkg::phys_addr(head_ff, k_in);
                  full_in     = (count_ff == bpq_pkg::cnt_type'(bpq_pkg::CAPACITY));
                  state_in    = full_in ? ST_EVICT : ST_SCAN;
               end
            end
         end
         ST_POP: begin
            res_in.out_valid = 1'b1;
            res_in.item      = ram_rd_data;
            res_in.dropped   = 1'b0;
            head_in  = bpq_pkg::phys_addr(head_ff, bpq_pkg::ptr_type'(1));
            count_in = count_ff - bpq_pkg::cnt_type'(1);
            state_in = ST_DONE;
         end
         ST_EVICT: begin
            res_in.out_valid = 1'b1;
            res_in.dropped   = 1'b1;
            if (ram_rd_data.prio >= item_ff.prio) begin
               // The new item ranks at or below the tail, so it is dropped itself.
               res_in.item = item_ff;
               state_in    = ST_DONE;
            end else begin
               // The tail is dropped; the scan shifts entries over its slot.
               res_in.item = ram_rd_data;
               k_in        = bpq_pkg::PTR_W'(bpq_pkg::CAPACITY - 2);
               ram_rd.en   = 1'b1;
               ram_rd.addr = bpq_pkg::phys_addr(head_ff, k_in);
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = bpq_pkg::phys_addr(head_ff, k_ff + bpq_pkg::ptr_type'(1));
            if (ram_rd_data.prio < item_ff.prio) begin
               ram_wr.data = ram_rd_data;
               if (k_ff == '0) begin
                  state_in = ST_PLACE;
               end else begin
                  k_in        = k_ff - bpq_pkg::ptr_type'(1);
                  ram_rd.en   = 1'b1;
                  ram_rd.addr = bpq_pkg::phys_addr(head_ff, k_in);
               end
            end else begin
               ram_wr.data = item_ff;
               insert_done = 1'b1;
            end
         end
         ST_PLACE: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = head_ff;
            ram_wr.data = item_ff;
            insert_done = 1'b1;
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_taken) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (insert_done) begin
         if (!full_ff) begin
            count_in = count_ff + bpq_pkg::cnt_type'(1);
         end
         state_in = ST_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      item_ff <= item_in;
      full_ff <= full_in;
      res_ff  <= res_in;
   end

   always_comb begin
      res           = res_ff;
      res.occupancy = bpq_pkg::OCC_W'(count_ff);
   end

   `BPQ_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= bpq_pkg::cnt_type'(bpq_pkg::CAPACITY), "entry count above capacity")
   `BPQ_ASSERT_ALWAYS(a_no_rw_clash, clock, reset, !(ram_wr.en && ram_rd.en && (ram_wr.addr == ram_rd.addr)), "read and write hit the same slot")
   `BPQ_ASSERT_NEXT(a_res_held, clock, reset, res_valid && !res_taken, res_valid && $stable(res), "pending result changed before hand-off")

endmodule

// ----- rtl/core/bounded_priority_queue.sv -----
// Top level of the bounded priority queue: sequencer, entry store and result register.
// Depends on bpq_pkg, bpq_ctrl and bpq_ram.
`timescale 1ns / 1ps

// The queue holds up to 16 entries sorted by descending priority, with entries
// of equal priority kept in arrival order. Every accepted request yields exactly
// one result transfer. A dequeue returns the head entry (rsp_out_valid low when
// the queue is empty). An enqueue returns nothing valid unless the queue was
// full, in which case the lowest-ranked entry, possibly the new item, is
// reported with rsp_dropped high. rsp_occupancy is the count after the request.
// Entries live in a ring in a single memory with one write and one registered
// read port; a dequeue only reads the head slot and moves the head pointer.
// An enqueue walks the list from the tail, reading one entry and writing it
// one slot down per cycle until the insertion point is found; when the queue
// was full, the tail entry is first compared with the new item. When the
// queue is full and the new item ranks at or below the tail entry, the new
// item itself is dropped without a scan. The result sits in an output
// register; a request is taken as soon as the previous result has moved into
// that register, while it still waits for rsp_ready.
module bounded_priority_queue (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_command,
   input  logic [7:0] req_item_value,
   input  logic [7:0] req_priority_req,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_out_valid,
   output logic [7:0] rsp_out_value,
   output logic [7:0] rsp_out_priority,
   output logic       rsp_dropped,
   output logic [4:0] rsp_occupancy
);

   bpq_pkg::entry_type   req_item;
   bpq_pkg::result_type  res;
   logic                 res_valid;
   logic                 out_free;
   bpq_pkg::ram_wr_type  ram_wr;
   bpq_pkg::ram_rd_type  ram_rd;
   bpq_pkg::entry_type   ram_rd_data;

   logic                 rsp_valid_ff, rsp_valid_in;
   bpq_pkg::result_type  rsp_data_ff, rsp_data_in;

   assign req_item.value = req_item_value;
   assign req_item.prio  = req_priority_req;

   // The output register can take a new result when it is empty or when its
   // current result is transferred in this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   bpq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_item    (req_item),
      .res_valid   (res_valid),
      .res         (res),
      .res_taken   (out_free),
      .ram_wr      (ram_wr),
      .ram_rd      (ram_rd),
      .ram_rd_data (ram_rd_data)
   );

   bpq_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_valid    = rsp_data_ff.out_valid;
   assign rsp_out_value    = rsp_data_ff.item.value;
   assign rsp_out_priority = rsp_data_ff.item.prio;
   assign rsp_dropped      = rsp_data_ff.dropped;
   assign rsp_occupancy    = rsp_data_ff.occupancy;

endmodule
